[hw/rtl/b2u_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2u_pkg
// Shared widths, coefficient sets and helper functions for the BGR to UYVY
// 4:2:2 converter.
// ----------------------------------------------------------------------------
package b2u_pkg;

    localparam int unsigned PIX_W          = 8;
    localparam int unsigned FRAME_HEIGHT_W = 13;
    localparam logic [FRAME_HEIGHT_W-1:0] SD_HEIGHT_LIMIT    = 13'd576;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

    localparam int unsigned COEF_W = 9;
    // Coefficient times an unsigned byte, signed.
    localparam int unsigned PROD_W = 17;
    // Three products plus the rounding term.
    localparam int unsigned SUM_W  = 19;
    localparam int unsigned FRAC_W = 8;
    // Weighted value after the floor shift.
    localparam int unsigned WGT_W  = SUM_W - FRAC_W;
    // Offsets, pair sums and averages before clamping.
    localparam int unsigned OUT_W  = 13;

    // Row and column codes of a coefficient set.
    localparam int unsigned ROW_LUMA = 0;
    localparam int unsigned ROW_CB   = 1;
    localparam int unsigned ROW_CR   = 2;
    localparam int unsigned COL_RED  = 0;
    localparam int unsigned COL_GRN  = 1;
    localparam int unsigned COL_BLU  = 2;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [2:0][2:0] t_coef_set;

    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

    function automatic t_coef_set coef_set(input logic bt709);
        t_coef_set c;
        if (bt709) begin
            c[ROW_LUMA][COL_RED] = 9'sd47;
            c[ROW_LUMA][COL_GRN] = 9'sd157;
            c[ROW_LUMA][COL_BLU] = 9'sd16;
            c[ROW_CB][COL_RED]   = -9'sd26;
            c[ROW_CB][COL_GRN]   = -9'sd87;
            c[ROW_CB][COL_BLU]   = 9'sd112;
            c[ROW_CR][COL_RED]   = 9'sd112;
            c[ROW_CR][COL_GRN]   = -9'sd102;
            c[ROW_CR][COL_BLU]   = -9'sd10;
        end else begin
            c[ROW_LUMA][COL_RED] = 9'sd66;
            c[ROW_LUMA][COL_GRN] = 9'sd129;
            c[ROW_LUMA][COL_BLU] = 9'sd25;
            c[ROW_CB][COL_RED]   = -9'sd38;
            c[ROW_CB][COL_GRN]   = -9'sd74;
            c[ROW_CB][COL_BLU]   = 9'sd112;
            c[ROW_CR][COL_RED]   = 9'sd112;
            c[ROW_CR][COL_GRN]   = -9'sd94;
            c[ROW_CR][COL_BLU]   = -9'sd18;
        end
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [OUT_W-1:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 255) begin
            r = '1;
        end else begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/bgra_to_uyvy_422_converter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgra_to_uyvy_422_converter_unit
// Converts one horizontal pair of BGR pixels to one UYVY 4:2:2 group.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock while o_stall is low and passes
// it through products, row sums with the floor shift, then offsets, chroma
// averaging and clamping, each behind a register with its own valid bit. A
// stall on the output holds only the stages that are full, so bubbles close
// up and the input keeps accepting until the whole chain is occupied. The
// coefficient set (BT.601 for a frame height of at most 576, otherwise
// BT.709) is decoded when frame_height is written; write it only while no
// beat is in flight. The configuration port is always ready.
// ----------------------------------------------------------------------------
module bgra_to_uyvy_422_converter_unit
    import b2u_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration write channel.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [FRAME_HEIGHT_W-1:0] i_cfg_frame_height,
    // Pixel pair input.
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [PIX_W-1:0]          i_blue_first,
    input  wire logic [PIX_W-1:0]          i_green_first,
    input  wire logic [PIX_W-1:0]          i_red_first,
    input  wire logic [PIX_W-1:0]          i_blue_second,
    input  wire logic [PIX_W-1:0]          i_green_second,
    input  wire logic [PIX_W-1:0]          i_red_second,
    input  wire logic                      i_second_absent,
    // UYVY output.
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [PIX_W-1:0]               o_cb_average,
    output logic [PIX_W-1:0]               o_luma_first,
    output logic [PIX_W-1:0]               o_cr_average,
    output logic [PIX_W-1:0]               o_luma_second
);

    logic r_use_bt709;
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    t_stage_en stage_en;
    t_coef_set coef;

    logic [PIX_W-1:0] red_b, green_b, blue_b;

    logic signed [WGT_W-1:0] y0_w, cb0_w, cr0_w;
    logic signed [WGT_W-1:0] y1_w, cb1_w, cr1_w;

    logic [PIX_W-1:0] r_cb, r_y0, r_cr, r_y1;
    logic [PIX_W-1:0] n_cb, n_y0, n_cr, n_y1;

    // A full stage advances when the one after it can take its beat.
    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign stage_en = '{s1: en1, s2: en2};

    assign o_stall     = !en1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_bt709 <= (FRAME_HEIGHT_RESET > SD_HEIGHT_LIMIT);
        end else if (i_cfg_valid) begin
            r_use_bt709 <= (i_cfg_frame_height > SD_HEIGHT_LIMIT);
        end
    end

    assign coef = coef_set(r_use_bt709);

    // At an odd-width row end the first pixel stands in for the second.
    assign red_b   = i_second_absent ? i_red_first   : i_red_second;
    assign green_b = i_second_absent ? i_green_first : i_green_second;
    assign blue_b  = i_second_absent ? i_blue_first  : i_blue_second;

    b2u_pixel_mac u_mac_first (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_coef   (coef),
        .i_red    (i_red_first),
        .i_green  (i_green_first),
        .i_blue   (i_blue_first),
        .o_luma_w (y0_w),
        .o_cb_w   (cb0_w),
        .o_cr_w   (cr0_w)
    );

    b2u_pixel_mac u_mac_second (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_coef   (coef),
        .i_red    (red_b),
        .i_green  (green_b),
        .i_blue   (blue_b),
        .o_luma_w (y1_w),
        .o_cb_w   (cb1_w),
        .o_cr_w   (cr1_w)
    );

    always_comb begin
        logic signed [OUT_W-1:0] cb_sum, cr_sum, cb_avg, cr_avg;
        cb_sum = OUT_W'(cb0_w) + OUT_W'(cb1_w) + OUT_W'(256);
        cr_sum = OUT_W'(cr0_w) + OUT_W'(cr1_w) + OUT_W'(256);
        // The arithmetic shift floors, so a negative sum is bumped first to make the halving truncate toward zero.
        cb_avg = (cb_sum + signed'(OUT_W'(cb_sum < 0))) >>> 1;
        cr_avg = (cr_sum + signed'(OUT_W'(cr_sum < 0))) >>> 1;
        n_cb = clamp8(cb_avg);
        n_cr = clamp8(cr_avg);
        n_y0 = clamp8(OUT_W'(y0_w) + OUT_W'(16));
        n_y1 = clamp8(OUT_W'(y1_w) + OUT_W'(16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_cb <= n_cb;
            r_y0 <= n_y0;
            r_cr <= n_cr;
            r_y1 <= n_y1;
        end
    end

    assign o_valid       = r_v3;
    assign o_cb_average  = r_cb;
    assign o_luma_first  = r_y0;
    assign o_cr_average  = r_cr;
    assign o_luma_second = r_y1;

endmodule
`default_nettype wire

[hw/rtl/b2u_pixel_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2u_pixel_mac
// Two-stage weighted sum of one pixel: registered products, then the three
// row sums with rounding and the floor shift by 256.
// ----------------------------------------------------------------------------
module b2u_pixel_mac
    import b2u_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_stage_en               i_en,
    input  wire t_coef_set               i_coef,
    input  wire logic [PIX_W-1:0]        i_red,
    input  wire logic [PIX_W-1:0]        i_green,
    input  wire logic [PIX_W-1:0]        i_blue,
    output logic signed [WGT_W-1:0]      o_luma_w,
    output logic signed [WGT_W-1:0]      o_cb_w,
    output logic signed [WGT_W-1:0]      o_cr_w
);

    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic signed [WGT_W-1:0]  r_wgt  [3];
    logic signed [WGT_W-1:0]  n_wgt  [3];

    always_comb begin
        logic signed [PROD_W-1:0] pix [3];
        pix[COL_RED] = signed'(PROD_W'(i_red));
        pix[COL_GRN] = signed'(PROD_W'(i_green));
        pix[COL_BLU] = signed'(PROD_W'(i_blue));
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = PROD_W'(signed'(PROD_W'(signed'(i_coef[r][c]))) * pix[c]);
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        for (int r = 0; r < 3; r++) begin
            sum = SUM_W'(r_prod[r][COL_RED]) + SUM_W'(r_prod[r][COL_GRN])
                + SUM_W'(r_prod[r][COL_BLU]) + SUM_W'(128);
            // Arithmetic shift gives the floor for negative sums as well.
            n_wgt[r] = WGT_W'(sum >>> FRAC_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod <= n_prod;
        end
        if (i_en.s2) begin
            r_wgt <= n_wgt;
        end
    end

    assign o_luma_w = r_wgt[ROW_LUMA];
    assign o_cb_w   = r_wgt[ROW_CB];
    assign o_cr_w   = r_wgt[ROW_CR];

endmodule
`default_nettype wire
